// ===== hdl/boolean_token_expression_evaluator_defines.svh =====
// Assertion macros shared by the boolean token expression evaluator RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef BOOLEAN_TOKEN_EXPRESSION_EVALUATOR_DEFINES_SVH
`define BOOLEAN_TOKEN_EXPRESSION_EVALUATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BTE_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bte assertion failed");
// next-cycle implication
`define BTE_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bte assertion failed");
`else
`define BTE_ASSERT_IMP(label, ck, rn, ante, cons)
`define BTE_ASSERT_NXT(label, ck, rn, ante, cons)
`endif

`endif

// ===== hdl/bte_pkg.sv =====
// Types and codes for the boolean token expression evaluator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bte_pkg;

    // token kinds
    localparam logic [3:0] TK_NONE  = 4'd0;
    localparam logic [3:0] TK_OPEN  = 4'd1;
    localparam logic [3:0] TK_CLOSE = 4'd2;
    localparam logic [3:0] TK_AND   = 4'd3;
    localparam logic [3:0] TK_OR    = 4'd4;
    localparam logic [3:0] TK_NOT   = 4'd5;
    localparam logic [3:0] TK_FALSE = 4'd6;
    localparam logic [3:0] TK_TRUE  = 4'd7;
    localparam logic [3:0] TK_PRED  = 4'd8;

    // predicate outcomes (anything else means the predicate failed)
    localparam logic [1:0] PO_FALSE = 2'd0;
    localparam logic [1:0] PO_TRUE  = 2'd1;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_VALUE  = 3'd1;
    localparam logic [2:0] ST_BAD_TOKEN = 3'd2;
    localparam logic [2:0] ST_PRED_FAIL = 3'd3;
    localparam logic [2:0] ST_UNBALANCED = 3'd4;
    localparam logic [2:0] ST_TOO_DEEP  = 3'd5;

    typedef enum logic [1:0] {
        OPND_NONE  = 2'd0,
        OPND_FALSE = 2'd1,
        OPND_TRUE  = 2'd2
    } opnd_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_AND  = 2'd1,
        OP_OR   = 2'd2
    } op_t;

    // one nesting level, packed {neg, op, right, left}
    typedef struct packed {
        logic  neg;
        op_t   op;
        opnd_t right;
        opnd_t left;
    } level_t;

    // stack control from the evaluator
    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctl_t;

    // one result request toward the output buffer
    typedef struct packed {
        logic       valid;
        logic       value;
        logic [2:0] status;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/bte_in_if.sv =====
// Token channel: valid/ready handshake with the token payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface bte_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [1:0] predicate_outcome;
    logic       expr_end;

    modport source (output valid, output token_kind, output predicate_outcome,
                    output expr_end, input ready);
    modport sink   (input valid, input token_kind, input predicate_outcome,
                    input expr_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/bte_out_if.sv =====
// Result channel: valid/ready handshake with value and status.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface bte_out_if;
    logic       valid;
    logic       ready;
    logic       value;
    logic [2:0] status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/bte_stack.sv =====
// Level stack: memory of saved levels plus a registered top-of-stack copy.
// Depends on bte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bte_stack
    import bte_pkg::*;
#(
    parameter int MAX_DEPTH = 16
)
(
    input  logic                               clk,
    input  stack_ctl_t                         ctl,
    input  level_t                             push_data,
    input  logic [$clog2(MAX_DEPTH + 1) - 1:0] depth,
    output level_t                             top
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    level_t          mem [MAX_DEPTH];
    level_t          top_reg;
    logic [DW - 1:0] below_top;
    logic [AW - 1:0] waddr;
    logic [AW - 1:0] raddr;

    // push writes at depth; a pop needs the entry under the current top
    assign below_top = depth - DW'(2);
    assign waddr     = depth[AW - 1:0];
    assign raddr     = below_top[AW - 1:0];

    // write port, with the pushed level bypassed into the top copy
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[waddr] <= push_data;
            top_reg    <= push_data;
        end
        else if (ctl.pop)
        begin
            top_reg <= mem[raddr];
        end
    end

    assign top = top_reg;

endmodule

`default_nettype wire

// ===== hdl/bte_eval.sv =====
// Token evaluator: current level, nesting depth and drain flag, one token per cycle while accept is high.
// Depends on bte_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "boolean_token_expression_evaluator_defines.svh"

module bte_eval
    import bte_pkg::*;
#(
    parameter int MAX_DEPTH = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [3:0]                         token_kind,
    input  logic [1:0]                         predicate_outcome,
    input  logic                               expr_end,
    input  level_t                             top,
    output stack_ctl_t                         sctl,
    output level_t                             push_data,
    output logic [$clog2(MAX_DEPTH + 1) - 1:0] depth,
    output result_t                            rslt
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam level_t LEVEL_CLEAR = '{neg: 1'b0, op: OP_NONE, right: OPND_NONE,
                                       left: OPND_NONE};

    level_t          lvl_reg, lvl_next;
    logic [DW - 1:0] depth_reg, depth_next;
    logic            drain_reg, drain_next;

    level_t          cur;
    logic [DW - 1:0] depth_n;
    opnd_t           tmp;
    logic            has_opnd;
    logic            em;
    opnd_t           em_opnd;
    logic [2:0]      em_status;
    logic [2:0]      st;

    function automatic logic lvl_ready(level_t l);
        return (l.left != OPND_NONE) && (l.right != OPND_NONE) && (l.op != OP_NONE);
    endfunction

    function automatic level_t lvl_apply(level_t l);
        level_t r;
        logic   a;
        logic   b;
        logic   v;
        r = l;
        a = (l.left == OPND_TRUE);
        b = (l.right == OPND_TRUE);
        v = (l.op == OP_AND) ? (a & b) : (a | b);
        r.left  = v ? OPND_TRUE : OPND_FALSE;
        r.right = OPND_NONE;
        r.op    = OP_NONE;
        return r;
    endfunction

    // next level, depth and result for the accepted token
    always_comb
    begin
        cur        = lvl_reg;
        depth_n    = depth_reg;
        tmp        = OPND_NONE;
        has_opnd   = 1'b0;
        em         = 1'b0;
        em_opnd    = OPND_NONE;
        em_status  = ST_OK;
        sctl       = '{push: 1'b0, pop: 1'b0};
        push_data  = lvl_reg;
        lvl_next   = lvl_reg;
        depth_next = depth_reg;
        drain_next = drain_reg;
        st         = ST_OK;
        rslt       = '{valid: 1'b0, value: 1'b0, status: ST_OK};

        if (accept)
        begin
            if (drain_reg)
            begin
                // tokens are dropped until the end of the expression
                if (expr_end)
                begin
                    lvl_next   = LEVEL_CLEAR;
                    depth_next = '0;
                    drain_next = 1'b0;
                end
            end
            else
            begin
                if (lvl_ready(cur))
                begin
                    cur = lvl_apply(cur);
                end

                case (token_kind)
                    TK_OPEN:
                    begin
                        if (depth_reg >= DW'(MAX_DEPTH))
                        begin
                            em        = 1'b1;
                            em_status = ST_TOO_DEEP;
                        end
                        else
                        begin
                            sctl.push = 1'b1;
                            push_data = cur;
                            depth_n   = depth_reg + DW'(1);
                            cur       = LEVEL_CLEAR;
                        end
                    end
                    TK_CLOSE:
                    begin
                        if (depth_reg == '0)
                        begin
                            // close at top level ends the expression
                            em      = 1'b1;
                            em_opnd = cur.left;
                        end
                        else
                        begin
                            sctl.pop = 1'b1;
                            depth_n  = depth_reg - DW'(1);
                            tmp      = cur.left;
                            cur      = top;
                            if (tmp == OPND_NONE)
                            begin
                                em        = 1'b1;
                                em_status = ST_NO_VALUE;
                            end
                            else
                            begin
                                has_opnd = 1'b1;
                            end
                        end
                    end
                    TK_AND:
                    begin
                        cur.op = OP_AND;
                    end
                    TK_OR:
                    begin
                        cur.op = OP_OR;
                    end
                    TK_NOT:
                    begin
                        cur.neg = ~cur.neg;
                    end
                    TK_FALSE:
                    begin
                        tmp      = OPND_FALSE;
                        has_opnd = 1'b1;
                    end
                    TK_TRUE:
                    begin
                        tmp      = OPND_TRUE;
                        has_opnd = 1'b1;
                    end
                    TK_PRED:
                    begin
                        // short-circuit ignores the outcome
                        if (cur.left == OPND_FALSE && cur.op == OP_AND)
                        begin
                            tmp      = OPND_FALSE;
                            has_opnd = 1'b1;
                        end
                        else if (cur.left == OPND_TRUE && cur.op == OP_OR)
                        begin
                            tmp      = OPND_TRUE;
                            has_opnd = 1'b1;
                        end
                        else if (predicate_outcome == PO_FALSE)
                        begin
                            tmp      = OPND_FALSE;
                            has_opnd = 1'b1;
                        end
                        else if (predicate_outcome == PO_TRUE)
                        begin
                            tmp      = OPND_TRUE;
                            has_opnd = 1'b1;
                        end
                        else
                        begin
                            em        = 1'b1;
                            em_status = ST_PRED_FAIL;
                        end
                    end
                    default:
                    begin
                        em        = 1'b1;
                        em_status = ST_BAD_TOKEN;
                    end
                endcase

                // place the operand; a third one with no pending op is dropped
                if (has_opnd)
                begin
                    if (cur.neg)
                    begin
                        tmp     = (tmp == OPND_FALSE) ? OPND_TRUE : OPND_FALSE;
                        cur.neg = 1'b0;
                    end
                    if (cur.left == OPND_NONE)
                    begin
                        cur.left = tmp;
                    end
                    else if (cur.right == OPND_NONE)
                    begin
                        cur.right = tmp;
                    end
                end

                // end of expression
                if (!em && expr_end)
                begin
                    em = 1'b1;
                    if (depth_n != '0)
                    begin
                        em_status = ST_UNBALANCED;
                    end
                    else
                    begin
                        if (lvl_ready(cur))
                        begin
                            cur = lvl_apply(cur);
                        end
                        em_opnd = cur.left;
                    end
                end

                if (em)
                begin
                    st = (em_status == ST_OK && em_opnd == OPND_NONE) ? ST_NO_VALUE
                                                                      : em_status;
                    rslt.valid  = 1'b1;
                    rslt.status = st;
                    rslt.value  = (st == ST_OK) && (em_opnd == OPND_TRUE);
                    sctl        = '{push: 1'b0, pop: 1'b0};
                    lvl_next    = LEVEL_CLEAR;
                    depth_next  = '0;
                    drain_next  = !expr_end;
                end
                else
                begin
                    lvl_next   = cur;
                    depth_next = depth_n;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg   <= LEVEL_CLEAR;
            depth_reg <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            lvl_reg   <= lvl_next;
            depth_reg <= depth_next;
            drain_reg <= drain_next;
        end
    end

    assign depth = depth_reg;

    `BTE_ASSERT_IMP(a_depth_bound, clk, rst_n, 1'b1, depth_reg <= DW'(MAX_DEPTH))
    `BTE_ASSERT_IMP(a_drain_no_result, clk, rst_n, drain_reg, !rslt.valid)
    `BTE_ASSERT_NXT(a_result_clears, clk, rst_n, rslt.valid, depth_reg == '0 && lvl_reg == LEVEL_CLEAR)

endmodule

`default_nettype wire

// ===== hdl/bte_outbuf.sv =====
// Result output register with one skid entry behind it.
// Depends on bte_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "boolean_token_expression_evaluator_defines.svh"

module bte_outbuf
    import bte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  result_t    rslt,
    input  logic       out_ready,
    output logic       in_ready,
    output logic       out_valid,
    output logic       out_value,
    output logic [2:0] out_status
);

    logic       out_valid_reg, out_valid_next;
    logic       out_value_reg, out_value_next;
    logic [2:0] out_status_reg, out_status_next;
    logic       skid_valid_reg, skid_valid_next;
    logic       skid_value_reg, skid_value_next;
    logic [2:0] skid_status_reg, skid_status_next;
    logic       out_fire;

    assign out_fire = out_valid_reg && out_ready;

    // refill the output from the skid entry first, else from the new request
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_value_next  = skid_value_reg;
        skid_status_next = skid_status_reg;

        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_value_next  = skid_value_reg;
                out_status_next = skid_status_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (rslt.valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_next  = 1'b1;
                out_value_next  = rslt.value;
                out_status_next = rslt.status;
            end
            else
            begin
                skid_valid_next  = 1'b1;
                skid_value_next  = rslt.value;
                skid_status_next = rslt.status;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
        skid_value_reg  <= skid_value_next;
        skid_status_reg <= skid_status_next;
    end

    assign in_ready   = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

    `BTE_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `BTE_ASSERT_IMP(a_no_request_when_full, clk, rst_n, skid_valid_reg, !rslt.valid)
    `BTE_ASSERT_NXT(a_skid_moves_up, clk, rst_n, skid_valid_reg && out_ready, !skid_valid_reg)

endmodule

`default_nettype wire

// ===== hdl/boolean_token_expression_evaluator.sv =====
// Boolean token expression evaluator: takes one token per cycle and evaluates the
// expression left to right, emitting value and status at the last token, a top-level
// close or an error. A token is taken in every cycle, back to back, while the result
// side keeps up; a result is registered in the output register, or in its skid entry
// while the output is held. tok.ready falls only when the output register and its one
// skid entry both hold results, so the input stalls only after two results wait.
// Nesting up to MAX_DEPTH levels is kept in a memory with a registered top-of-stack
// copy; there is no clearing pass after reset.
// Depends on bte_pkg, bte_in_if, bte_out_if, bte_stack, bte_eval and bte_outbuf.
`timescale 1ns / 1ps
`default_nettype none

module boolean_token_expression_evaluator
    import bte_pkg::*;
#(
    parameter int MAX_DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    bte_in_if.sink   tok,
    bte_out_if.source res
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    stack_ctl_t      sctl;
    level_t          push_data;
    level_t          top;
    logic [DW - 1:0] depth;
    result_t         rslt;
    logic            in_ready;
    logic            accept;

    assign accept    = tok.valid && in_ready;
    assign tok.ready = in_ready;

    // evaluation of the accepted token
    bte_eval #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_eval (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .token_kind        (tok.token_kind),
        .predicate_outcome (tok.predicate_outcome),
        .expr_end          (tok.expr_end),
        .top               (top),
        .sctl              (sctl),
        .push_data         (push_data),
        .depth             (depth),
        .rslt              (rslt)
    );

    // saved levels
    bte_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .clk       (clk),
        .ctl       (sctl),
        .push_data (push_data),
        .depth     (depth),
        .top       (top)
    );

    // result buffering
    bte_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .rslt       (rslt),
        .out_ready  (res.ready),
        .in_ready   (in_ready),
        .out_valid  (res.valid),
        .out_value  (res.value),
        .out_status (res.status)
    );

endmodule

`default_nettype wire
